@@ rtl/phsf_pkg.sv @@
// ----------------------------------------------------------------------------
// phsf_pkg
// Shared widths, register indexes, reset values and handoff types of the
// high-pass sync framer.
// ----------------------------------------------------------------------------
package phsf_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int IN_SHIFT   = 8;
    localparam int COEF_W     = 15;
    localparam int COEF_FRAC  = 15;
    localparam int SHIFT_W    = 4;
    localparam int BLEN_W     = 13;
    localparam int PCM_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam int PROD_W     = SAMPLE_W + COEF_W + 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_SHIFT  = 2'd0,
        CFG_FILTER_COEF = 2'd1,
        CFG_BLOCK_LEN   = 2'd2
    } cfg_idx_t;

    localparam logic [SHIFT_W-1:0] GAIN_SHIFT_RST = 4'd4;
    localparam logic [COEF_W-1:0]  COEF_RST       = 15'd31226;
    localparam logic [BLEN_W-1:0]  BLEN_RST       = 13'd1024;

    localparam logic [BYTE_W-1:0] SYNC_A = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_B = 8'h5A;

    // filtered and clamped sample handed from the filter to the framer
    typedef struct packed {
        logic             valid;
        logic [PCM_W-1:0] pcm;
    } phsf_sample_t;

endpackage

@@ rtl/phsf_filter.sv @@
// ----------------------------------------------------------------------------
// phsf_filter
// Cascade of one-pole Q15 high-pass sections on one shared multiplier and
// adder, followed by the gain shift and int16 clamp.
// ----------------------------------------------------------------------------
module phsf_filter
    import phsf_pkg::*;
#(
    parameter int STAGES = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic [SHIFT_W-1:0]         gain_shift,
    input  logic [COEF_W-1:0]          filter_coef,
    output phsf_sample_t               sample_out,
    input  logic                       sample_taken
);

    localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int SUM_W = SAMPLE_W + 4;
    localparam int FB_W  = PROD_W - COEF_FRAC;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_SCALE,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [STG_W-1:0]           stage_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [PCM_W-1:0]           pcm_reg;
    logic signed [SAMPLE_W-1:0] prev_in_reg  [STAGES];
    logic signed [SAMPLE_W-1:0] prev_out_reg [STAGES];

    logic signed [SAMPLE_W-1:0] pout_sel;
    logic signed [SAMPLE_W-1:0] pin_sel;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [FB_W-1:0]     fb;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic signed [SAMPLE_W-1:0] scaled;
    logic [PCM_W-1:0]           pcm_next;
    logic                       last_stage;

    assign pout_sel   = prev_out_reg[stage_reg];
    assign pin_sel    = prev_in_reg[stage_reg];
    assign last_stage = (stage_reg == STG_W'(STAGES - 1));

    // the shared multiplier: this section's previous output times the coefficient
    assign prod_next = PROD_W'(pout_sel * $signed({1'b0, filter_coef}));

    // floor shift by the Q15 fraction is just dropping the low bits
    assign fb  = prod_reg[PROD_W-1:COEF_FRAC];
    assign sum = SUM_W'(x_reg) - SUM_W'(pin_sel) + SUM_W'(fb);

    always_comb begin
        if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1) begin
            y_sat = sum[SAMPLE_W-1:0];
        end else if (sum[SUM_W-1]) begin
            y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    assign scaled = x_reg >>> gain_shift;

    always_comb begin
        if (scaled[SAMPLE_W-1:PCM_W-1] == '0 || scaled[SAMPLE_W-1:PCM_W-1] == '1) begin
            pcm_next = scaled[PCM_W-1:0];
        end else if (scaled[SAMPLE_W-1]) begin
            pcm_next = {1'b1, {(PCM_W-1){1'b0}}};
        end else begin
            pcm_next = {1'b0, {(PCM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stage_reg <= '0;
            for (int i = 0; i < STAGES; i++) begin
                prev_in_reg[i]  <= '0;
                prev_out_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        x_reg     <= in_sample >>> IN_SHIFT;
                        stage_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    prev_in_reg[stage_reg]  <= x_reg;
                    prev_out_reg[stage_reg] <= y_sat;
                    x_reg                   <= y_sat;
                    if (last_stage) begin
                        state_reg <= ST_SCALE;
                    end else begin
                        stage_reg <= stage_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_SCALE: begin
                    pcm_reg   <= pcm_next;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (sample_taken) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign sample_out.valid = (state_reg == ST_DONE);
    assign sample_out.pcm   = pcm_reg;

endmodule

@@ rtl/phsf_framer.sv @@
// ----------------------------------------------------------------------------
// phsf_framer
// Byte sequencer: sync header at frame start, then the sample low byte and
// high byte, with the frame position counter.
// ----------------------------------------------------------------------------
module phsf_framer
    import phsf_pkg::*;
#(
    parameter int MAX_BLOCK = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  phsf_sample_t      sample_in,
    output logic              sample_taken,
    input  logic [BLEN_W-1:0] block_len,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int POS_W = $clog2(MAX_BLOCK + 1);
    localparam int LEN_W = (POS_W > BLEN_W) ? POS_W : BLEN_W;

    localparam logic [2:0] BYTE_FIRST = 3'd0;
    localparam logic [2:0] BYTE_LO    = 3'd4;
    localparam logic [2:0] BYTE_HI    = 3'd5;

    logic             busy_reg;
    logic [2:0]       idx_reg;
    logic [PCM_W-1:0] pcm_reg;
    logic [POS_W-1:0] pos_reg;

    logic [LEN_W-1:0] blen_ext;
    logic [LEN_W-1:0] len_wide;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pos_inc;

    assign blen_ext = LEN_W'(block_len);

    // zero length acts as one, anything above the frame limit saturates
    always_comb begin
        if (blen_ext == '0) begin
            len_wide = LEN_W'(1);
        end else if (blen_ext > LEN_W'(MAX_BLOCK)) begin
            len_wide = LEN_W'(MAX_BLOCK);
        end else begin
            len_wide = blen_ext;
        end
    end

    assign len          = POS_W'(len_wide);
    assign pos_inc      = pos_reg + 1'b1;
    assign sample_taken = sample_in.valid && !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= BYTE_FIRST;
            pos_reg  <= '0;
        end else begin
            if (sample_taken) begin
                busy_reg <= 1'b1;
                pcm_reg  <= sample_in.pcm;
                idx_reg  <= (pos_reg == '0) ? BYTE_FIRST : BYTE_LO;
                pos_reg  <= (pos_inc >= len) ? '0 : pos_inc;
            end else if (busy_reg && m_tready) begin
                if (idx_reg == BYTE_HI) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (idx_reg)
            BYTE_LO: m_tdata = pcm_reg[BYTE_W-1:0];
            BYTE_HI: m_tdata = pcm_reg[PCM_W-1:BYTE_W];
            default: m_tdata = idx_reg[0] ? SYNC_B : SYNC_A;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tuser  = (idx_reg < BYTE_LO);
    assign m_tlast  = (idx_reg == BYTE_HI);

endmodule

@@ rtl/pcm_highpass_sync_framer.sv @@
// ----------------------------------------------------------------------------
// pcm_highpass_sync_framer
// DC-blocking high-pass cascade on microphone words with a framed byte
// stream output carrying a sync header at the start of every block.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                    tuser     tlast
//  s_*       in   left_sample[31:0]        -         -
//  m_*       out  out_byte[7:0]            is_magic  last (sample high byte)
//  cfg_*     in   gain shift / filter_coef / block_len by cfg_addr
//
//  one sample passes through the filter as accept, a multiply and an add step
//  per section on the shared multiplier, scale, handoff
//  the framer sends 2 bytes, or 6 at a frame start, overlapping the next sample
//  m_tready low holds the byte sequencer; the filter then waits after scaling
//  aresetn is synchronous; it clears filter history and frame position
// ----------------------------------------------------------------------------
module pcm_highpass_sync_framer
    import phsf_pkg::*;
#(
    parameter int STAGES    = 3,
    parameter int MAX_BLOCK = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,     // [31:0] left_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,     // [7:0] out_byte
    output logic                  m_tuser,     // [0] is_magic
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [SHIFT_W-1:0] gain_shift_reg;
    logic [COEF_W-1:0]  coef_reg;
    logic [BLEN_W-1:0]  blen_reg;

    phsf_sample_t sample;
    logic         sample_taken;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_shift_reg <= GAIN_SHIFT_RST;
            coef_reg       <= COEF_RST;
            blen_reg       <= BLEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_GAIN_SHIFT:  gain_shift_reg <= cfg_wr_data[SHIFT_W-1:0];
                CFG_FILTER_COEF: coef_reg       <= cfg_wr_data[COEF_W-1:0];
                CFG_BLOCK_LEN:   blen_reg       <= cfg_wr_data[BLEN_W-1:0];
                default: ;
            endcase
        end
    end

    phsf_filter #(
        .STAGES(STAGES)
    ) u_filter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_sample   ($signed(s_tdata)),
        .gain_shift  (gain_shift_reg),
        .filter_coef (coef_reg),
        .sample_out  (sample),
        .sample_taken(sample_taken)
    );

    phsf_framer #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_in   (sample),
        .sample_taken(sample_taken),
        .block_len   (blen_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

@@ rtl/phsf_checker.sv @@
// ----------------------------------------------------------------------------
// phsf_checker
// Port-level checks of the high-pass sync framer, bound to the top level.
// ----------------------------------------------------------------------------
module phsf_checker
    import phsf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [BYTE_W-1:0]     m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // a sample occupies the shared unit after it is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // the closing byte of a transaction group is always sample data
    a_last_not_magic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser)
        else $error("sync byte flagged as last");

    // sync header bytes only carry the two magic codes
    a_magic_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == SYNC_A || m_tdata == SYNC_B))
        else $error("sync byte with wrong value");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output transaction changed");

endmodule

bind pcm_highpass_sync_framer phsf_checker u_phsf_checker (.*);
